// File: sv/nsem_pkg.sv
`default_nettype none
package nsem_pkg;

  // table geometry
  localparam int SLOT_COUNT  = 64;
  localparam int NAME_BYTES  = 16;
  localparam int QUEUE_DEPTH = 16;
  localparam int PID_BITS    = 16;

  localparam int IDX_W    = $clog2(SLOT_COUNT);
  localparam int USE_W    = $clog2(SLOT_COUNT + 1);
  localparam int QHW      = $clog2(QUEUE_DEPTH);
  localparam int QFW      = $clog2(QUEUE_DEPTH + 1);
  localparam int QA_W     = $clog2(SLOT_COUNT * QUEUE_DEPTH);
  localparam int NAME_W   = 120;
  localparam int COUNT_W  = 7;
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PW  = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW  = $clog2(CMDQ_DEPTH + 1);

  localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

  // item kinds
  localparam logic [2:0] K_CREATE = 3'd0;
  localparam logic [2:0] K_OPEN   = 3'd1;
  localparam logic [2:0] K_WAIT   = 3'd2;
  localparam logic [2:0] K_POST   = 3'd3;
  localparam logic [2:0] K_CLOSE  = 3'd4;
  localparam logic [2:0] K_WDRAW  = 3'd5;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BLOCKED  = 3'd1;
  localparam logic [2:0] ST_UNUSED   = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_QFULL    = 3'd4;
  localparam logic [2:0] ST_NOTFOUND = 3'd5;
  localparam logic [2:0] ST_SAT      = 3'd6;

  typedef struct packed {
    logic [2:0]  kind;
    logic [5:0]  sem_index;
    logic [6:0]  init_value;
    logic [63:0] name_first;
    logic [55:0] name_rest;
    logic [15:0] caller_pid;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  slot_out;
    logic        wake_valid;
    logic [15:0] wake_pid;
    logic [6:0]  count_now;
  } out_item_t;

  // classified command passed from front to engine
  typedef struct packed {
    logic [2:0]          kind;
    logic [5:0]          sem_index;
    logic                idx_ok;
    logic [IDX_W-1:0]    idx;
    logic [COUNT_W-1:0]  init;
    logic [NAME_W-1:0]   name;
    logic [PID_BITS-1:0] pid;
  } cmd_t;

  // per-slot bookkeeping word
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [QHW-1:0]     head;
    logic [QFW-1:0]     fill;
  } meta_t;

  // zero every byte after the first zero byte and past the name limit
  function automatic logic [NAME_W-1:0] canon_name(logic [63:0] f, logic [55:0] r);
    logic [NAME_W-1:0] w;
    logic ended;
    w = {r, f};
    ended = 1'b0;
    for (int i = 0; i < 15; i++) begin
      if (ended || (i >= NAME_BYTES - 1) || (w[i*8 +: 8] == 8'd0)) begin
        ended = 1'b1;
        w[i*8 +: 8] = 8'd0;
      end
    end
    return w;
  endfunction

endpackage
`default_nettype wire

// File: sv/nsem_ram.sv
`default_nettype none
module nsem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: sv/nsem_front.sv
`default_nettype none
module nsem_front (
  input  wire nsem_pkg::in_item_t item,
  output nsem_pkg::cmd_t          cmd
);
  // classify the transaction and put the name in canonical form
  always_comb begin
    cmd.kind      = item.kind;
    cmd.sem_index = item.sem_index;
    cmd.idx_ok    = (32'(item.sem_index) < nsem_pkg::SLOT_COUNT);
    cmd.idx       = nsem_pkg::IDX_W'(item.sem_index);
    cmd.init      = item.init_value;
    cmd.name      = nsem_pkg::canon_name(item.name_first, item.name_rest);
    cmd.pid       = nsem_pkg::PID_BITS'(item.caller_pid);
  end
endmodule
`default_nettype wire

// File: sv/nsem_cmdq.sv
`default_nettype none
module nsem_cmdq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire nsem_pkg::cmd_t push_data,
  input  wire logic           pop,
  output nsem_pkg::cmd_t      head,
  output logic                full,
  output logic                empty
);
  nsem_pkg::cmd_t ent_r [nsem_pkg::CMDQ_DEPTH];
  logic [nsem_pkg::CMDQ_PW-1:0] wp_r, rp_r;
  logic [nsem_pkg::CMDQ_CW-1:0] cnt_r;

  assign full  = (cnt_r == nsem_pkg::CMDQ_CW'(nsem_pkg::CMDQ_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = ent_r[rp_r];

  function automatic logic [nsem_pkg::CMDQ_PW-1:0] bump(logic [nsem_pkg::CMDQ_PW-1:0] p);
    return (32'(p) == nsem_pkg::CMDQ_DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      ent_r[wp_r] <= push_data;
    end
  end

  // pointers and fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) wp_r <= bump(wp_r);
      if (pop && !empty) rp_r <= bump(rp_r);
      cnt_r <= cnt_r + nsem_pkg::CMDQ_CW'(push && !full) - nsem_pkg::CMDQ_CW'(pop && !empty);
    end
  end
endmodule
`default_nettype wire

// File: sv/nsem_engine.sv
`default_nettype none
module nsem_engine (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cmd_avail,
  input  wire nsem_pkg::cmd_t cmd_in,
  output logic                cmd_pop,
  output logic                res_valid,
  output nsem_pkg::out_item_t res
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_FIND  = 4'd2;
  localparam logic [3:0] S_ORD   = 4'd3;
  localparam logic [3:0] S_OCMP  = 4'd4;
  localparam logic [3:0] S_OMETA = 4'd5;
  localparam logic [3:0] S_META  = 4'd6;
  localparam logic [3:0] S_POST  = 4'd7;
  localparam logic [3:0] S_WRD   = 4'd8;
  localparam logic [3:0] S_WCMP  = 4'd9;
  localparam logic [3:0] S_SRD   = 4'd10;
  localparam logic [3:0] S_SWR   = 4'd11;

  localparam int IW  = nsem_pkg::IDX_W;
  localparam int QFW = nsem_pkg::QFW;
  localparam int QHW = nsem_pkg::QHW;
  localparam int QAW = nsem_pkg::QA_W;

  logic [3:0] state_r, state_nxt;
  nsem_pkg::cmd_t cmd_r, cmd_nxt;
  nsem_pkg::meta_t meta_r, meta_nxt;
  logic [IW-1:0] scan_r, scan_nxt;
  logic [QFW-1:0] k_r, k_nxt;
  logic [nsem_pkg::SLOT_COUNT-1:0] used_r, used_nxt;
  logic [nsem_pkg::USE_W-1:0] in_use_r, in_use_nxt;
  logic [IW-1:0] search_r, search_nxt;
  logic res_valid_r, res_valid_nxt;
  nsem_pkg::out_item_t res_r, res_nxt;

  // memory ports
  logic name_we;
  logic [nsem_pkg::NAME_W-1:0] name_rdata;
  logic meta_we;
  logic [IW-1:0] meta_waddr, meta_raddr;
  nsem_pkg::meta_t meta_wdata, meta_rdata;
  logic q_we;
  logic [QAW-1:0] q_waddr, q_raddr;
  logic [nsem_pkg::PID_BITS-1:0] q_rdata;
  logic [nsem_pkg::PID_BITS-1:0] q_rdata_sel;

  nsem_ram #(.WIDTH(nsem_pkg::NAME_W), .DEPTH(nsem_pkg::SLOT_COUNT)) u_name_ram (
    .clk(clk), .we(name_we), .waddr(scan_r), .wdata(cmd_r.name),
    .raddr(scan_r), .rdata(name_rdata));

  nsem_ram #(.WIDTH($bits(nsem_pkg::meta_t)), .DEPTH(nsem_pkg::SLOT_COUNT)) u_meta_ram (
    .clk(clk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
    .raddr(meta_raddr), .rdata(meta_rdata));

  nsem_ram #(.WIDTH(nsem_pkg::PID_BITS),
             .DEPTH(nsem_pkg::SLOT_COUNT * nsem_pkg::QUEUE_DEPTH)) u_queue_ram (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_rdata_sel),
    .raddr(q_raddr), .rdata(q_rdata));

  // ring position inside a slot's queue
  function automatic logic [QHW-1:0] qwrap(logic [QHW-1:0] h, logic [QFW-1:0] off);
    logic [QFW:0] s;
    s = (QFW+1)'(h) + (QFW+1)'(off);
    if (s >= (QFW+1)'(nsem_pkg::QUEUE_DEPTH)) s = s - (QFW+1)'(nsem_pkg::QUEUE_DEPTH);
    return QHW'(s);
  endfunction

  function automatic logic [QAW-1:0] qaddr(logic [IW-1:0] idx, logic [QHW-1:0] h,
                                           logic [QFW-1:0] off);
    return QAW'(QAW'(idx) * QAW'(nsem_pkg::QUEUE_DEPTH)) + QAW'(qwrap(h, off));
  endfunction

  function automatic logic [IW-1:0] next_slot(logic [IW-1:0] s);
    return (32'(s) == nsem_pkg::SLOT_COUNT - 1) ? '0 : s + 1'b1;
  endfunction

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    meta_nxt      = meta_r;
    scan_nxt      = scan_r;
    k_nxt         = k_r;
    used_nxt      = used_r;
    in_use_nxt    = in_use_r;
    search_nxt    = search_r;
    res_valid_nxt = 1'b0;
    res_nxt       = '0;
    cmd_pop       = 1'b0;
    name_we       = 1'b0;
    meta_we       = 1'b0;
    meta_waddr    = cmd_r.idx;
    meta_raddr    = cmd_r.idx;
    meta_wdata    = meta_r;
    q_we          = 1'b0;
    q_waddr       = qaddr(cmd_r.idx, meta_r.head, k_r);
    q_raddr       = qaddr(cmd_r.idx, meta_r.head, k_r);
    q_rdata_sel   = q_rdata;

    case (state_r)
      S_IDLE: begin
        if (cmd_avail) begin
          cmd_pop   = 1'b1;
          cmd_nxt   = cmd_in;
          state_nxt = S_DISP;
        end
      end

      S_DISP: begin
        case (cmd_r.kind)
          nsem_pkg::K_CREATE: begin
            if (32'(in_use_r) >= nsem_pkg::SLOT_COUNT) begin
              res_nxt.status = nsem_pkg::ST_FULL;
              res_valid_nxt  = 1'b1;
              state_nxt      = S_IDLE;
            end else begin
              scan_nxt  = search_r;
              state_nxt = S_FIND;
            end
          end
          nsem_pkg::K_OPEN: begin
            scan_nxt  = '0;
            state_nxt = S_ORD;
          end
          nsem_pkg::K_WAIT, nsem_pkg::K_POST, nsem_pkg::K_CLOSE, nsem_pkg::K_WDRAW: begin
            if (!cmd_r.idx_ok || !used_r[cmd_r.idx]) begin
              res_nxt.status   = nsem_pkg::ST_UNUSED;
              res_nxt.slot_out = cmd_r.sem_index;
              res_valid_nxt    = 1'b1;
              state_nxt        = S_IDLE;
            end else begin
              state_nxt = S_META;
            end
          end
          default: begin
            res_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        endcase
      end

      // round-robin search for a free slot
      S_FIND: begin
        if (!used_r[scan_r]) begin
          name_we            = 1'b1;
          meta_we            = 1'b1;
          meta_waddr         = scan_r;
          meta_wdata         = '0;
          meta_wdata.count   = cmd_r.init;
          used_nxt[scan_r]   = 1'b1;
          in_use_nxt         = in_use_r + 1'b1;
          search_nxt         = next_slot(scan_r);
          res_nxt.slot_out   = 6'(scan_r);
          res_nxt.count_now  = cmd_r.init;
          res_valid_nxt      = 1'b1;
          state_nxt          = S_IDLE;
        end else begin
          scan_nxt = next_slot(scan_r);
        end
      end

      // open: name read issued at scan_r, compare next cycle
      S_ORD: begin
        if (used_r[scan_r]) begin
          state_nxt = S_OCMP;
        end else if (32'(scan_r) == nsem_pkg::SLOT_COUNT - 1) begin
          res_nxt.status = nsem_pkg::ST_NOTFOUND;
          res_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end

      S_OCMP: begin
        meta_raddr = scan_r;
        if (name_rdata == cmd_r.name) begin
          state_nxt = S_OMETA;
        end else if (32'(scan_r) == nsem_pkg::SLOT_COUNT - 1) begin
          res_nxt.status = nsem_pkg::ST_NOTFOUND;
          res_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          scan_nxt  = scan_r + 1'b1;
          state_nxt = S_ORD;
        end
      end

      S_OMETA: begin
        res_nxt.slot_out  = 6'(scan_r);
        res_nxt.count_now = meta_rdata.count;
        res_valid_nxt     = 1'b1;
        state_nxt         = S_IDLE;
      end

      // slot bookkeeping is available: carry out the command
      S_META: begin
        meta_nxt         = meta_rdata;
        res_nxt.slot_out = cmd_r.sem_index;
        state_nxt        = S_IDLE;
        case (cmd_r.kind)
          nsem_pkg::K_WAIT: begin
            res_valid_nxt = 1'b1;
            if (meta_rdata.count != '0) begin
              meta_we           = 1'b1;
              meta_wdata        = meta_rdata;
              meta_wdata.count  = meta_rdata.count - 1'b1;
              res_nxt.count_now = meta_rdata.count - 1'b1;
            end else if (32'(meta_rdata.fill) >= nsem_pkg::QUEUE_DEPTH) begin
              res_nxt.status = nsem_pkg::ST_QFULL;
            end else begin
              q_we            = 1'b1;
              q_waddr         = qaddr(cmd_r.idx, meta_rdata.head, meta_rdata.fill);
              q_rdata_sel     = cmd_r.pid;
              meta_we         = 1'b1;
              meta_wdata      = meta_rdata;
              meta_wdata.fill = meta_rdata.fill + 1'b1;
              res_nxt.status  = nsem_pkg::ST_BLOCKED;
            end
          end
          nsem_pkg::K_POST: begin
            if (meta_rdata.fill != '0) begin
              q_raddr   = qaddr(cmd_r.idx, meta_rdata.head, '0);
              state_nxt = S_POST;
            end else if (meta_rdata.count >= nsem_pkg::COUNT_MAX) begin
              res_nxt.status    = nsem_pkg::ST_SAT;
              res_nxt.count_now = meta_rdata.count;
              res_valid_nxt     = 1'b1;
            end else begin
              meta_we           = 1'b1;
              meta_wdata        = meta_rdata;
              meta_wdata.count  = meta_rdata.count + 1'b1;
              res_nxt.count_now = meta_rdata.count + 1'b1;
              res_valid_nxt     = 1'b1;
            end
          end
          nsem_pkg::K_CLOSE: begin
            used_nxt[cmd_r.idx] = 1'b0;
            if (in_use_r != '0) in_use_nxt = in_use_r - 1'b1;
            res_valid_nxt = 1'b1;
          end
          default: begin
            if (meta_rdata.fill == '0) begin
              res_nxt.status    = nsem_pkg::ST_NOTFOUND;
              res_nxt.count_now = meta_rdata.count;
              res_valid_nxt     = 1'b1;
            end else begin
              k_nxt     = '0;
              state_nxt = S_WRD;
            end
          end
        endcase
      end

      // post: oldest waiter is on the queue read port
      S_POST: begin
        meta_we            = 1'b1;
        meta_wdata         = meta_r;
        meta_wdata.head    = qwrap(meta_r.head, QFW'(1));
        meta_wdata.fill    = meta_r.fill - 1'b1;
        res_nxt.slot_out   = cmd_r.sem_index;
        res_nxt.wake_valid = 1'b1;
        res_nxt.wake_pid   = 16'(q_rdata);
        res_nxt.count_now  = meta_r.count;
        res_valid_nxt      = 1'b1;
        state_nxt          = S_IDLE;
      end

      // withdraw: walk the queue for the pid
      S_WRD: begin
        state_nxt = S_WCMP;
      end

      S_WCMP: begin
        if (q_rdata == cmd_r.pid) begin
          if ((k_r + QFW'(1)) < meta_r.fill) begin
            state_nxt = S_SRD;
          end else begin
            meta_we           = 1'b1;
            meta_wdata        = meta_r;
            meta_wdata.fill   = meta_r.fill - 1'b1;
            res_nxt.slot_out  = cmd_r.sem_index;
            res_nxt.count_now = meta_r.count;
            res_valid_nxt     = 1'b1;
            state_nxt         = S_IDLE;
          end
        end else if ((k_r + QFW'(1)) < meta_r.fill) begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_WRD;
        end else begin
          res_nxt.status    = nsem_pkg::ST_NOTFOUND;
          res_nxt.slot_out  = cmd_r.sem_index;
          res_nxt.count_now = meta_r.count;
          res_valid_nxt     = 1'b1;
          state_nxt         = S_IDLE;
        end
      end

      // close the gap: entry k takes entry k+1
      S_SRD: begin
        q_raddr   = qaddr(cmd_r.idx, meta_r.head, k_r + QFW'(1));
        state_nxt = S_SWR;
      end

      S_SWR: begin
        q_we = 1'b1;
        if ((k_r + QFW'(2)) < meta_r.fill) begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_SRD;
        end else begin
          meta_we           = 1'b1;
          meta_wdata        = meta_r;
          meta_wdata.fill   = meta_r.fill - 1'b1;
          res_nxt.slot_out  = cmd_r.sem_index;
          res_nxt.count_now = meta_r.count;
          res_valid_nxt     = 1'b1;
          state_nxt         = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      in_use_r    <= '0;
      search_r    <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      in_use_r    <= in_use_nxt;
      search_r    <= search_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    meta_r <= meta_nxt;
    scan_r <= scan_nxt;
    k_r    <= k_nxt;
    res_r  <= res_nxt;
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;
endmodule
`default_nettype wire

// File: sv/named_counting_semaphore_table_top.sv
// channel   ports                  transaction
// input     start, busy, in_item   start && !busy at a rising edge
// result    out_valid, out_item    out_valid high for one cycle, always taken
//
// Items pass through a two-entry command queue to a sequencing engine.
// Wait, post and close read the slot bookkeeping first (an unused slot is refused before
// that read, and a post that wakes also reads the waiter queue); create scans for a free slot,
// open does one name RAM read per used slot, and withdraw walks and shifts the queue RAM.
// Reset is synchronous, active low, and clears all slots at once.
// busy rises while the command queue is full; results cannot be held off.
`default_nettype none
module named_counting_semaphore_table_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire nsem_pkg::in_item_t  in_item,
  output logic                     out_valid,
  output nsem_pkg::out_item_t      out_item
);
  nsem_pkg::cmd_t front_cmd, q_head;
  logic q_full, q_empty, q_pop;

  nsem_front u_front (
    .item(in_item),
    .cmd (front_cmd)
  );

  nsem_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (start),
    .push_data(front_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  nsem_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_avail(!q_empty),
    .cmd_in   (q_head),
    .cmd_pop  (q_pop),
    .res_valid(out_valid),
    .res      (out_item)
  );

  assign busy = q_full;

  // checks
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("results on consecutive cycles");

  a_wake_implies_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.wake_valid) |->
      (out_item.count_now == '0 && out_item.status == nsem_pkg::ST_OK))
    else $error("wake with nonzero count");

  a_blocked_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == nsem_pkg::ST_BLOCKED) |->
      (out_item.count_now == '0 && !out_item.wake_valid))
    else $error("blocked with nonzero count");

  a_pid_clear_without_wake: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.wake_valid) |-> out_item.wake_pid == '0)
    else $error("stray wake pid");

  a_quiet_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result right after reset");
endmodule
`default_nettype wire
